FILE: rtl/evad_pkg.sv
package evad_pkg;

  localparam int unsigned MAX_FRAME_SAMPLES = 512;

  // A full frame of magnitudes up to 32768 needs log2(samples) + 16 bits.
  localparam int unsigned SUM_W   = $clog2(MAX_FRAME_SAMPLES) + 16;
  localparam int unsigned COUNT_W = $clog2(MAX_FRAME_SAMPLES + 1);
  localparam int unsigned STEP_W  = $clog2(SUM_W);

  localparam logic [15:0] START_THR_RST = 16'd900;
  localparam logic [15:0] CONT_THR_RST  = 16'd500;
  localparam logic [9:0]  HOLD_RST      = 10'd125;

  typedef enum logic [1:0] {
    CFG_START_THR = 2'd0,
    CFG_CONT_THR  = 2'd1,
    CFG_HOLD      = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic capture;
    logic accumulate;
    logic div_load;
    logic div_step;
    logic emit;
  } evad_cmd_t;

  typedef struct packed {
    logic frame_end;
    logic div_last;
    logic out_free;
  } evad_sts_t;

endpackage

FILE: rtl/evad_if.sv
interface evad_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] left_word;
  logic signed [31:0] right_word;
  logic               frame_end;
  logic               suppress;

  modport source (output valid, left_word, right_word, frame_end, suppress, input ready);
  modport sink   (input valid, left_word, right_word, frame_end, suppress, output ready);
endinterface

interface evad_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] mono_sample;
  logic               frame_done;
  logic        [15:0] frame_level;
  logic               frame_voiced;
  logic               speaking_now;
  logic               speech_started;
  logic               speech_ended;

  modport source (output valid, mono_sample, frame_done, frame_level, frame_voiced,
                  speaking_now, speech_started, speech_ended, input ready);
  modport sink   (input valid, mono_sample, frame_done, frame_level, frame_voiced,
                  speaking_now, speech_started, speech_ended, output ready);
endinterface

interface evad_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [15:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

FILE: rtl/evad_ctrl.sv
module evad_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  evad_pkg::evad_sts_t sts_i,
  output evad_pkg::evad_cmd_t cmd_o
);
  import evad_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ACC,
    ST_LOAD,
    ST_DIV,
    ST_EMIT
  } state_e;

  state_e state_q, state_d;

  assign in_ready_o = (state_q == ST_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = ST_ACC;
        end
      end
      ST_ACC: begin
        cmd_o.accumulate = 1'b1;
        state_d          = sts_i.frame_end ? ST_LOAD : ST_EMIT;
      end
      ST_LOAD: begin
        cmd_o.div_load = 1'b1;
        state_d        = ST_DIV;
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

FILE: rtl/evad_datapath.sv
module evad_datapath (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic signed [31:0]  left_word_i,
  input  logic signed [31:0]  right_word_i,
  input  logic                frame_end_i,
  input  logic                suppress_i,
  input  evad_pkg::evad_cmd_t cmd_i,
  output evad_pkg::evad_sts_t sts_o,
  evad_cfg_if.sink            cfg_i,
  evad_out_if.source          out_o
);
  import evad_pkg::*;

  logic [15:0] start_thr_q, cont_thr_q;
  logic [9:0]  hold_q;

  logic signed [15:0] mono_q;
  logic               end_q, sup_q;

  logic [SUM_W-1:0]   sum_q;
  logic [COUNT_W-1:0] count_q;

  logic [SUM_W-1:0]   quo_q;
  logic [COUNT_W-1:0] rem_q, divisor_q;
  logic [STEP_W-1:0]  step_q;
  logic               div_zero_q;

  logic [9:0] quiet_q;
  logic       speaking_q, turn_q;

  logic signed [16:0] pair_sum, pair_adj;
  logic signed [15:0] mono;
  logic [15:0]        mono_abs;
  logic [COUNT_W:0]   trial;
  logic               trial_ge;
  logic [15:0]        level, thr;
  logic               voiced, cand;
  logic [9:0]         quiet_d;
  logic               speaking_d, turn_d, started, ended;

  // Truncation toward zero: an odd negative sum is nudged up before the shift.
  assign pair_sum = 17'($signed(left_word_i[31:16])) + 17'($signed(right_word_i[31:16]));
  assign pair_adj = pair_sum + 17'(pair_sum[16] & pair_sum[0]);
  assign mono     = pair_adj[16:1];
  assign mono_abs = mono_q[15] ? (~mono_q + 16'd1) : mono_q;

  assign trial    = {rem_q, quo_q[SUM_W-1]};
  assign trial_ge = (trial >= {1'b0, divisor_q});

  assign level = div_zero_q ? 16'd0 : quo_q[15:0];
  assign thr   = speaking_q ? cont_thr_q : start_thr_q;

  always_comb begin
    voiced     = (level >= thr);
    quiet_d    = quiet_q;
    started    = 1'b0;
    ended      = 1'b0;
    speaking_d = speaking_q;
    turn_d     = turn_q;
    if (voiced) begin
      quiet_d = '0;
    end else if (quiet_q < hold_q) begin
      quiet_d = quiet_q + 10'd1;
    end
    cand = voiced | (quiet_d < hold_q);
    if (sup_q) begin
      speaking_d = 1'b0;
    end else if (cand != speaking_q) begin
      speaking_d = cand;
      if (cand) begin
        turn_d  = 1'b1;
        started = 1'b1;
      end else if (turn_q) begin
        turn_d = 1'b0;
        ended  = 1'b1;
      end
    end
  end

  assign sts_o.frame_end = end_q;
  assign sts_o.div_last  = (step_q == '0);
  assign sts_o.out_free  = !out_o.valid || out_o.ready;
  assign cfg_i.ready     = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_thr_q <= START_THR_RST;
      cont_thr_q  <= CONT_THR_RST;
      hold_q      <= HOLD_RST;
    end else if (cfg_i.valid) begin
      case (cfg_i.index)
        CFG_START_THR: start_thr_q <= cfg_i.data;
        CFG_CONT_THR:  cont_thr_q  <= cfg_i.data;
        CFG_HOLD:      hold_q      <= cfg_i.data[9:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      mono_q <= mono;
      end_q  <= frame_end_i;
      sup_q  <= suppress_i;
    end
    if (cmd_i.div_load) begin
      quo_q      <= sum_q;
      rem_q      <= '0;
      divisor_q  <= count_q;
      step_q     <= STEP_W'(SUM_W - 1);
      div_zero_q <= (count_q == '0);
    end else if (cmd_i.div_step) begin
      rem_q  <= trial_ge ? COUNT_W'(trial - {1'b0, divisor_q}) : trial[COUNT_W-1:0];
      quo_q  <= {quo_q[SUM_W-2:0], trial_ge};
      step_q <= step_q - STEP_W'(1);
    end
    if (cmd_i.emit) begin
      out_o.mono_sample    <= mono_q;
      out_o.frame_done     <= end_q;
      out_o.frame_level    <= end_q ? level : 16'd0;
      out_o.frame_voiced   <= end_q & voiced;
      out_o.speaking_now   <= end_q ? speaking_d : speaking_q;
      out_o.speech_started <= end_q & started;
      out_o.speech_ended   <= end_q & ended;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q       <= '0;
      count_q     <= '0;
      quiet_q     <= HOLD_RST;
      speaking_q  <= 1'b0;
      turn_q      <= 1'b0;
      out_o.valid <= 1'b0;
    end else begin
      if (cmd_i.div_load) begin
        sum_q   <= '0;
        count_q <= '0;
      end else if (cmd_i.accumulate && (count_q < COUNT_W'(MAX_FRAME_SAMPLES))) begin
        sum_q   <= sum_q + SUM_W'(mono_abs);
        count_q <= count_q + COUNT_W'(1);
      end
      if (cmd_i.emit && end_q) begin
        quiet_q    <= quiet_d;
        speaking_q <= speaking_d;
        turn_q     <= turn_d;
      end
      if (cmd_i.emit) begin
        out_o.valid <= 1'b1;
      end else if (out_o.ready) begin
        out_o.valid <= 1'b0;
      end
    end
  end

endmodule

FILE: rtl/energy_vad_hysteresis_top.sv
// A result is registered into the output once its input is captured and accumulated;
// a frame-end item also passes through the bit-serial mean divider before it is emitted.
// A new item is taken only after the previous result is emitted, and the output register
// lets the next item start while a result waits to be taken, though its emit then stalls.
// Reset (rst_ni low, asynchronous) restores the default thresholds and hold count,
// clears the frame sum, the speaking state and any pending result.
module energy_vad_hysteresis_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  evad_in_if.sink    in_i,
  evad_cfg_if.sink   cfg_i,
  evad_out_if.source out_o
);
  import evad_pkg::*;

  evad_cmd_t cmd;
  evad_sts_t sts;

  evad_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  evad_datapath u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .left_word_i  (in_i.left_word),
    .right_word_i (in_i.right_word),
    .frame_end_i  (in_i.frame_end),
    .suppress_i   (in_i.suppress),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .cfg_i        (cfg_i),
    .out_o        (out_o)
  );

endmodule
